// ===== sv/sach_pkg.sv =====
package sach_pkg;

	localparam int MAX_SETS_DEF   = 1024;
	localparam int MAX_WAYS_DEF   = 8;
	localparam int ADDR_WIDTH_DEF = 32;

	// recency ranks are three bits and saturate
	localparam int          RANK_W   = 3;
	localparam logic [2:0]  RANK_MAX = 3'd7;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_MASK = 16'hB400;
	localparam int          LFSR_W    = 16;

	// register indexes of the configuration port
	localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
	localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;
	localparam logic [1:0] REG_POLICY      = 2'd3;

	localparam logic POLICY_LRU    = 1'b0;
	localparam logic POLICY_RANDOM = 1'b1;

	typedef struct packed {
		logic [3:0] offset_bits;
		logic [3:0] index_bits;
		logic [3:0] ways_in_use;
		logic       policy;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_LOOK,
		ST_DIV,
		ST_FIN
	} bk_state_t;

	// largest n with 2**n <= v, capped at 16
	function automatic int floor_log2(input int v);
		int n;
		n = 0;
		while (n < 16 && (64'd1 << (n + 1)) <= v) n++;
		return n;
	endfunction

endpackage

// ===== sv/sach_queue.sv =====
module sach_queue #(
	parameter int WIDTH = 42
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk) begin
		if (push) entry_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rptr_q];

endmodule

// ===== sv/sach_front.sv =====
module sach_front #(
	parameter int MAX_SETS   = sach_pkg::MAX_SETS_DEF,
	parameter int ADDR_WIDTH = sach_pkg::ADDR_WIDTH_DEF,
	parameter int SET_W      = 10
) (
	input  sach_pkg::cfg_t          cfg,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic [31:0]             address,
	input  logic                    q_full,
	output logic                    q_push,
	output logic [SET_W+ADDR_WIDTH-1:0] q_data
);

	localparam int IDX_LIM = sach_pkg::floor_log2(MAX_SETS);

	logic [ADDR_WIDTH-1:0] addr;
	logic [ADDR_WIDTH-1:0] shifted;
	logic [ADDR_WIDTH-1:0] idx_mask;
	logic [ADDR_WIDTH-1:0] tag;
	logic [4:0]            ib;
	logic [5:0]            sh;
	logic [SET_W-1:0]      set_idx;

	always_comb begin
		addr = ADDR_WIDTH'(address);
		ib = ({1'b0, cfg.index_bits} > 5'(IDX_LIM)) ? 5'(IDX_LIM) : {1'b0, cfg.index_bits};
		shifted  = addr >> cfg.offset_bits;
		idx_mask = ~({ADDR_WIDTH{1'b1}} << ib);
		set_idx  = SET_W'(shifted & idx_mask);
		sh = {2'b00, cfg.offset_bits} + {1'b0, ib};
		// tag vanishes when offset and index cover the whole address
		tag = (32'(sh) >= 32'(ADDR_WIDTH)) ? '0 : (addr >> sh);
	end

	assign req_ready = !q_full;
	assign q_push    = req_valid && !q_full;
	assign q_data    = {set_idx, tag};

endmodule

// ===== sv/sach_back.sv =====
module sach_back #(
	parameter int MAX_SETS   = sach_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS   = sach_pkg::MAX_WAYS_DEF,
	parameter int ADDR_WIDTH = sach_pkg::ADDR_WIDTH_DEF,
	parameter int SET_W      = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sach_pkg::cfg_t              cfg,
	input  logic                        q_not_empty,
	input  logic [SET_W+ADDR_WIDTH-1:0] q_head,
	output logic                        q_pop,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        hit,
	output logic [9:0]                  set_index,
	output logic [31:0]                 line_tag,
	output logic [2:0]                  way_used,
	output logic [31:0]                 hit_count,
	output logic [31:0]                 miss_count
);

	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int RW     = sach_pkg::RANK_W;
	localparam int ROW_W  = MAX_WAYS * (1 + ADDR_WIDTH + RW);

	typedef logic [MAX_WAYS-1:0]                 vld_vec_t;
	typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_vec_t;
	typedef logic [MAX_WAYS-1:0][RW-1:0]         rank_vec_t;

	sach_pkg::bk_state_t state_q, state_nx;

	logic [ROW_W-1:0]      row_mem [MAX_SETS];
	logic [ROW_W-1:0]      row_q;
	logic [SET_W-1:0]      clr_q;
	logic [SET_W-1:0]      set_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic [15:0]           lfsr_q;
	logic [15:0]           lfsr_nx;
	logic [15:0]           div_val_q;
	logic [3:0]            div_cnt_q;
	logic [WCNT_W:0]       rem_q;
	logic [WCNT_W:0]       rem_try;
	logic [31:0]           hits_q, misses_q, hits_nx, misses_nx;

	vld_vec_t  vld, vld_nx;
	tag_vec_t  tags, tags_nx;
	rank_vec_t ranks, ranks_nx;

	logic [WCNT_W-1:0] ways;
	logic              hit_d, empty_d, need_rand;
	logic [WAY_W-1:0]  hit_way, empty_way, lru_way, chosen;
	logic [RW-1:0]     best;
	logic [RW:0]       limit;
	logic              out_free, commit, wr_en;
	logic [SET_W-1:0]  wr_addr;
	logic [ROW_W-1:0]  wr_data;

	assign {vld, tags, ranks} = row_q;
	assign out_free = !rsp_valid || rsp_ready;

	// way count clamped to one..MAX_WAYS
	always_comb begin
		if (cfg.ways_in_use == 4'd0) ways = WCNT_W'(1);
		else if (32'(cfg.ways_in_use) > MAX_WAYS) ways = WCNT_W'(MAX_WAYS);
		else ways = WCNT_W'(cfg.ways_in_use);
	end

	// search of the set read from memory
	always_comb begin
		hit_d = 1'b0; hit_way = '0;
		empty_d = 1'b0; empty_way = '0;
		lru_way = '0; best = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (w < 32'(ways) && vld[w] && tags[w] == tag_q) begin
				hit_d = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < 32'(ways) && !vld[w]) begin
				empty_d = 1'b1;
				empty_way = WAY_W'(w);
			end
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < 32'(ways) && (w == 0 || ranks[w] > best)) begin
				best = ranks[w];
				lru_way = WAY_W'(w);
			end
		end
		need_rand = !hit_d && !empty_d && (cfg.policy == sach_pkg::POLICY_RANDOM);
	end

	// chosen way and new row contents
	always_comb begin
		if (state_q == sach_pkg::ST_FIN) chosen = WAY_W'(rem_q);
		else if (hit_d) chosen = hit_way;
		else if (empty_d) chosen = empty_way;
		else chosen = lru_way;
		limit = (!hit_d && empty_d && state_q != sach_pkg::ST_FIN) ?
			(RW+1)'(8) : {1'b0, ranks[chosen]};
		vld_nx = vld; tags_nx = tags; ranks_nx = ranks;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < 32'(ways) && WAY_W'(w) != chosen && vld[w] &&
				{1'b0, ranks[w]} < limit && ranks[w] < sach_pkg::RANK_MAX)
				ranks_nx[w] = ranks[w] + RW'(1);
		end
		ranks_nx[chosen] = '0;
		vld_nx[chosen]   = 1'b1;
		tags_nx[chosen]  = tag_q;
	end

	always_comb begin
		lfsr_nx = lfsr_q >> 1;
		if (lfsr_q[0]) lfsr_nx = lfsr_nx ^ sach_pkg::LFSR_MASK;
		rem_try = {rem_q[WCNT_W-1:0], div_val_q[15]};
		if (rem_try >= {1'b0, ways}) rem_try = rem_try - {1'b0, ways};
		hits_nx = hits_q; misses_nx = misses_q;
		if (hit_d && state_q != sach_pkg::ST_FIN) begin
			if (hits_q != sach_pkg::COUNT_MAX) hits_nx = hits_q + 32'd1;
		end else if (misses_q != sach_pkg::COUNT_MAX) begin
			misses_nx = misses_q + 32'd1;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			sach_pkg::ST_CLR:  if (clr_q == SET_W'(MAX_SETS - 1)) state_nx = sach_pkg::ST_IDLE;
			sach_pkg::ST_IDLE: if (q_not_empty) state_nx = sach_pkg::ST_LOOK;
			sach_pkg::ST_LOOK: begin
				if (need_rand) state_nx = sach_pkg::ST_DIV;
				else if (out_free) state_nx = sach_pkg::ST_IDLE;
			end
			sach_pkg::ST_DIV:  if (div_cnt_q == 4'd15) state_nx = sach_pkg::ST_FIN;
			sach_pkg::ST_FIN:  if (out_free) state_nx = sach_pkg::ST_IDLE;
			default:           state_nx = sach_pkg::ST_CLR;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop  = 1'b0;
		commit = 1'b0;
		case (state_q)
			sach_pkg::ST_IDLE: q_pop = q_not_empty;
			sach_pkg::ST_LOOK: commit = !need_rand && out_free;
			sach_pkg::ST_FIN:  commit = out_free;
			default: begin
				q_pop  = 1'b0;
				commit = 1'b0;
			end
		endcase
		wr_en   = (state_q == sach_pkg::ST_CLR) || commit;
		wr_addr = (state_q == sach_pkg::ST_CLR) ? clr_q : set_q;
		wr_data = (state_q == sach_pkg::ST_CLR) ? '0 : {vld_nx, tags_nx, ranks_nx};
	end

	always_ff @(posedge clk) begin
		if (wr_en) row_mem[wr_addr] <= wr_data;
		if (q_pop) row_q <= row_mem[q_head[SET_W+ADDR_WIDTH-1:ADDR_WIDTH]];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			set_q <= q_head[SET_W+ADDR_WIDTH-1:ADDR_WIDTH];
			tag_q <= q_head[ADDR_WIDTH-1:0];
		end
		if (state_q == sach_pkg::ST_LOOK && need_rand) div_val_q <= lfsr_nx;
		else if (state_q == sach_pkg::ST_DIV) div_val_q <= div_val_q << 1;
		if (commit) begin
			hit        <= hit_d && state_q != sach_pkg::ST_FIN;
			set_index  <= 10'(set_q);
			line_tag   <= 32'(tags_nx[chosen]);
			way_used   <= 3'(chosen);
			hit_count  <= hits_nx;
			miss_count <= misses_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sach_pkg::ST_CLR;
			clr_q     <= '0;
			lfsr_q    <= sach_pkg::LFSR_SEED;
			div_cnt_q <= '0;
			rem_q     <= '0;
			hits_q    <= '0;
			misses_q  <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == sach_pkg::ST_CLR) clr_q <= clr_q + SET_W'(1);
			if (state_q == sach_pkg::ST_LOOK && need_rand) begin
				lfsr_q    <= lfsr_nx;
				div_cnt_q <= '0;
				rem_q     <= '0;
			end else if (state_q == sach_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + 4'd1;
				rem_q     <= rem_try;
			end
			if (commit) begin
				hits_q    <= hits_nx;
				misses_q  <= misses_nx;
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sach_pkg::ST_CLR |-> !q_pop)
		else $error("queue popped during clearing pass");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid)
		else $error("committed request not presented");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sach_pkg::ST_DIV |-> rem_q < {1'b0, ways})
		else $error("remainder out of range");
	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> !commit)
		else $error("two commits in a row");
`endif

endmodule

// ===== sv/set_assoc_cache_hit_tracker_unit.sv =====
// Tag store of a set-associative cache that counts hits and misses and holds no data. Each
// request is a byte address, split into offset, set and tag by the offset_bits and
// index_bits registers; the set's ways are searched, a hit refreshes recency, a miss fills
// the highest empty way or replaces the least recently used or a pseudo-random way. A
// front stage decodes and queues up to two requests; the back part reads the set row from
// a single-port row memory (one row per set, all ways side by side) and writes it back.
// In the back part a request has a row read, then update and write-back; when a full set is
// replaced at random it has a row read, lookup, sixteen remainder steps and write-back,
// since the way is taken as the LFSR value modulo the way count by a bit-serial remainder
// of sixteen steps. The write-back waits while a result is held unaccepted. After reset the
// row memory is cleared one set a cycle, all MAX_SETS sets, before the first request is
// looked up; up to two requests may be queued meanwhile. Configuration writes are taken
// throughout and must only come while the block is idle.
module set_assoc_cache_hit_tracker_unit #(
	parameter int MAX_SETS   = sach_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS   = sach_pkg::MAX_WAYS_DEF,
	parameter int ADDR_WIDTH = sach_pkg::ADDR_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [31:0] address,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        hit,
	output logic [9:0]  set_index,
	output logic [31:0] line_tag,
	output logic [2:0]  way_used,
	output logic [31:0] hit_count,
	output logic [31:0] miss_count
);

	// set number width, at least one bit
	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int QW    = SET_W + ADDR_WIDTH;

	sach_pkg::cfg_t  cfg_q;
	logic            q_full, q_push, q_pop, q_not_empty;
	logic [QW-1:0]   q_data, q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_bits <= 4'd6;
			cfg_q.index_bits  <= 4'd6;
			cfg_q.ways_in_use <= 4'd8;
			cfg_q.policy      <= sach_pkg::POLICY_LRU;
		end else if (cfg_we) begin
			case (cfg_index)
				sach_pkg::REG_OFFSET_BITS: cfg_q.offset_bits <= cfg_data;
				sach_pkg::REG_INDEX_BITS:  cfg_q.index_bits  <= cfg_data;
				sach_pkg::REG_WAYS_IN_USE: cfg_q.ways_in_use <= cfg_data;
				sach_pkg::REG_POLICY:      cfg_q.policy      <= cfg_data[0];
				default:                   cfg_q             <= cfg_q;
			endcase
		end
	end

	// address decode into the queue
	sach_front #(
		.MAX_SETS   (MAX_SETS),
		.ADDR_WIDTH (ADDR_WIDTH),
		.SET_W      (SET_W)
	) u_front (
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.address   (address),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	// two-entry decoupling queue
	sach_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// lookup, replacement and write-back
	sach_back #(
		.MAX_SETS   (MAX_SETS),
		.MAX_WAYS   (MAX_WAYS),
		.ADDR_WIDTH (ADDR_WIDTH),
		.SET_W      (SET_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.hit         (hit),
		.set_index   (set_index),
		.line_tag    (line_tag),
		.way_used    (way_used),
		.hit_count   (hit_count),
		.miss_count  (miss_count)
	);

endmodule
